// ===== rtl/cisf_pkg.sv =====
`default_nettype none

package cisf_pkg;

   localparam int CHAR_BITS      = 8;
   localparam int WORD_BITS      = 64;
   localparam int LEN_BITS       = 5;
   localparam int START_BITS     = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int WORD_CHARS     = WORD_BITS / CHAR_BITS;

   localparam int DEF_MAX_PATTERN   = 16;
   localparam int DEF_POSITION_BITS = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [CHAR_BITS-1:0] UPPER_FIRST = 8'h41;
   localparam logic [CHAR_BITS-1:0] UPPER_LAST  = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CASE_OFFSET = 8'h20;

   typedef logic [CHAR_BITS-1:0] char_type;

   function automatic char_type fold_case(input char_type c);
      char_type r;
      r = c;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cisf_if.sv =====
`default_nettype none

interface cisf_req_if import cisf_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type text_char;
   logic     text_end;

   modport source (output valid, output text_char, output text_end, input ready);
   modport sink   (input valid, input text_char, input text_end, output ready);
endinterface

interface cisf_rsp_if import cisf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [START_BITS-1:0] match_start;
   logic                  position_overflow;

   modport source (output valid, output found, output match_start,
                   output position_overflow, input ready);
   modport sink   (input valid, input found, input match_start,
                   input position_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/case_insensitive_substring_find.sv =====
`default_nettype none

// Case-insensitive substring search over a character stream.
// req: one text character per beat, text_end marks the last character.
// rsp: one beat per text, sent for the text_end character: found, start
//      index of the first match (0 if none) and position_overflow.
// csr: write-only port; index 0/1 load pattern chars 0-7 / 8-15, index 2
//      the pattern length (0 matches at once, above MAX_PATTERN clamps).
// One character per clock while req is ready: the window compare against
// all pattern lengths is done in parallel in the accepting cycle.
// Latency: the rsp beat is valid the cycle after the text_end beat.
// The result sits in a single output register; req stays ready while
// that register is empty or is being drained in the same cycle, so a
// stalled rsp only holds off req once a result is waiting.
// Reset clears the pattern registers, the per-text state and rsp.valid.
// Positions count up to 2^POSITION_BITS and then hold; a match found
// past that point reports the top position with position_overflow set.

module case_insensitive_substring_find import cisf_pkg::*; #(
   parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   cisf_req_if.sink                    req,
   cisf_rsp_if.source                  rsp,
   input  wire                         csr_we,
   input  wire [CSR_IDX_BITS-1:0]      csr_index,
   input  wire [WORD_BITS-1:0]         csr_wdata
);

   localparam int SEL_BITS = (MAX_PATTERN < 2) ? 1 : $clog2(MAX_PATTERN + 1);
   localparam int CNT_BITS = POSITION_BITS + 1;
   localparam logic [START_BITS-1:0] MAX_START =
      (POSITION_BITS >= START_BITS) ? {START_BITS{1'b1}}
                                    : START_BITS'((64'd1 << POSITION_BITS) - 64'd1);

   logic [WORD_BITS-1:0] pat_low_ff, pat_high_ff;
   logic [LEN_BITS-1:0]  pat_len_ff;

   char_type             recent_ff [MAX_PATTERN];
   char_type             recent_in [MAX_PATTERN];
   logic [CNT_BITS-1:0]  seen_ff, seen_in;
   logic                 match_ff, match_in;
   logic [START_BITS-1:0] start_ff, start_in;
   logic                 sat_ff, sat_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;
   logic [START_BITS-1:0] rsp_start_ff;
   logic                  rsp_ovf_ff;

   logic                  accept;
   logic [LEN_BITS-1:0]   len_eff;
   logic [2*WORD_BITS-1:0] pat_all;
   char_type              pat_char [MAX_PATTERN];
   logic [MAX_PATTERN:0]  hit_vec;
   logic                  hit;
   logic                  eligible;
   logic [CNT_BITS:0]     seen_plus;
   logic [CNT_BITS:0]     start_full;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign len_eff = (pat_len_ff > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                          : pat_len_ff;
   assign pat_all = {pat_high_ff, pat_low_ff};

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pat_char[k] = fold_case(pat_all[k*CHAR_BITS +: CHAR_BITS]);
      end
   end

   always_comb begin
      recent_in[0] = fold_case(req.text_char);
      for (int i = 1; i < MAX_PATTERN; i++) begin
         recent_in[i] = recent_ff[i-1];
      end
   end

   // hit_vec[L]: the newest L characters equal pattern chars 0..L-1
   always_comb begin
      hit_vec[0] = 1'b1;
      for (int l = 1; l <= MAX_PATTERN; l++) begin
         hit_vec[l] = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (recent_in[l-1-k] != pat_char[k]) begin
               hit_vec[l] = 1'b0;
            end
         end
      end
   end

   assign hit        = hit_vec[len_eff[SEL_BITS-1:0]];
   assign seen_plus  = {1'b0, seen_ff} + (CNT_BITS+1)'(1);
   assign eligible   = seen_ff[POSITION_BITS] || (seen_plus >= (CNT_BITS+1)'(len_eff));
   assign start_full = seen_plus - (CNT_BITS+1)'(len_eff);

   always_comb begin
      match_in = match_ff;
      start_in = start_ff;
      sat_in   = sat_ff;
      if (!match_ff) begin
         if (len_eff == '0) begin
            match_in = 1'b1;
            start_in = '0;
            sat_in   = 1'b0;
         end else if (eligible && hit) begin
            match_in = 1'b1;
            if (seen_ff[POSITION_BITS]) begin
               start_in = MAX_START;
               sat_in   = 1'b1;
            end else begin
               start_in = START_BITS'(start_full);
               sat_in   = 1'b0;
            end
         end
      end
      seen_in = seen_ff[POSITION_BITS] ? seen_ff : seen_ff + CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_ff <= csr_wdata;
            CSR_PATTERN_LENGTH: pat_len_ff  <= csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // window needs no clear: a match only looks at chars of the current text
   always_ff @(posedge clock) begin
      if (accept) begin
         recent_ff <= recent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         match_ff <= 1'b0;
         start_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (accept) begin
         if (req.text_end) begin
            seen_ff  <= '0;
            match_ff <= 1'b0;
            start_ff <= '0;
            sat_ff   <= 1'b0;
         end else begin
            seen_ff  <= seen_in;
            match_ff <= match_in;
            start_ff <= start_in;
            sat_ff   <= sat_in;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && req.text_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.text_end) begin
         rsp_found_ff <= match_in;
         rsp_start_ff <= match_in ? start_in : '0;
         rsp_ovf_ff   <= match_in && sat_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.found             = rsp_found_ff;
   assign rsp.match_start       = rsp_start_ff;
   assign rsp.position_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
   import cisf_pkg::*;

   localparam int MAX_PATTERN   = DEF_MAX_PATTERN;
   localparam int POSITION_BITS = DEF_POSITION_BITS;
   localparam int POS_LIMIT     = 1 << POSITION_BITS;
   localparam int POS_TOP       = POS_LIMIT - 1;
   localparam int RUN_LIMIT     = 1_000_000;
   localparam int RANDOM_CHARS  = 1450;
   localparam int IDLE_PCT      = 11;
   localparam int DRAIN_CYCLES  = 3;

   localparam char_type LOWER_FIRST = 8'h61;
   localparam char_type LOWER_LAST  = 8'h7A;

   typedef struct packed {
      logic                  found;
      logic [START_BITS-1:0] start;
      logic                  ovf;
   } text_result_type;

   function automatic char_type fold_letter(char_type c);
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   // Tracks the search state per text and queues the outcome of each finished text.
   class match_tracker;
      logic [WORD_BITS-1:0]   pat_low;
      logic [WORD_BITS-1:0]   pat_high;
      logic [LEN_BITS-1:0]    pat_len;
      char_type               window [MAX_PATTERN];
      logic [POSITION_BITS:0] chars_seen;
      logic                   match_seen;
      logic [START_BITS-1:0]  first_start;
      logic                   saturated;
      text_result_type        pending_results [$];
      int                     mismatches;
      int                     checked;
      int                     hits;
      int                     overflows;

      function new();
         pat_low    = '0;
         pat_high   = '0;
         pat_len    = '0;
         mismatches = 0;
         checked    = 0;
         hits       = 0;
         overflows  = 0;
         clear_text();
      endfunction

      function void clear_text();
         foreach (window[i]) window[i] = '0;
         chars_seen  = '0;
         match_seen  = 1'b0;
         first_start = '0;
         saturated   = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
         case (idx)
            CSR_PATTERN_LOW: begin
               pat_low = data;
            end
            CSR_PATTERN_HIGH: begin
               pat_high = data;
            end
            CSR_PATTERN_LENGTH: begin
               pat_len = data[LEN_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function char_type pattern_at(int k);
         logic [WORD_BITS-1:0] word;
         word = (k < WORD_CHARS) ? pat_low : pat_high;
         return fold_letter(word[(k % WORD_CHARS) * CHAR_BITS +: CHAR_BITS]);
      endfunction

      function void take_char(char_type c, logic is_end);
         int              len;
         int              s;
         bit              hit;
         text_result_type r;
         len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
         for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = fold_letter(c);
         if (!match_seen) begin
            if (len == 0) begin
               match_seen  = 1'b1;
               first_start = '0;
               saturated   = 1'b0;
            end else if (chars_seen >= POS_LIMIT || int'(chars_seen) + 1 >= len) begin
               hit = 1'b1;
               for (int k = 0; k < len; k++) begin
                  if (window[len-1-k] != pattern_at(k)) hit = 1'b0;
               end
               if (hit) begin
                  match_seen = 1'b1;
                  s = int'(chars_seen) + 1 - len;
                  // past the counter range the exact start is lost
                  if (chars_seen >= POS_LIMIT || s > POS_TOP) begin
                     first_start = POS_TOP[START_BITS-1:0];
                     saturated   = 1'b1;
                  end else begin
                     first_start = s[START_BITS-1:0];
                     saturated   = 1'b0;
                  end
               end
            end
         end
         if (chars_seen < POS_LIMIT) chars_seen++;
         if (is_end) begin
            r.found = match_seen;
            r.start = match_seen ? first_start : '0;
            r.ovf   = match_seen && saturated;
            pending_results.push_back(r);
            clear_text();
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_beat(logic found, logic [START_BITS-1:0] start, logic ovf);
         text_result_type want;
         if (pending_results.size() == 0) begin
            report("rsp beat with no text awaiting a result");
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (found !== want.found) begin
            report($sformatf("result %0d found: expected %0b, got %0b",
                             checked, want.found, found));
         end
         if (start !== want.start) begin
            report($sformatf("result %0d match_start: expected %0d, got %0d",
                             checked, want.start, start));
         end
         if (ovf !== want.ovf) begin
            report($sformatf("result %0d position_overflow: expected %0b, got %0b",
                             checked, want.ovf, ovf));
         end
         if (want.found) hits++;
         if (want.ovf) overflows++;
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [WORD_BITS-1:0]    csr_wdata;

   cisf_req_if req_ch ();
   cisf_rsp_if rsp_ch ();

   case_insensitive_substring_find #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   match_tracker tracker = new();
   char_type     text_buf [$];
   char_type     pat_bytes [MAX_PATTERN];
   bit           gaps_on = 1'b1;
   int           chars_sent = 0;
   int           texts_sent = 0;
   int           cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: check each accepted beat, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_beat(rsp_ch.found, rsp_ch.match_start, rsp_ch.position_overflow);
      end
      rsp_ch.ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   function automatic char_type random_case(char_type c);
      char_type f;
      f = fold_letter(c);
      if (f >= LOWER_FIRST && f <= LOWER_LAST && $urandom_range(1) == 1) f = f - CASE_OFFSET;
      return f;
   endfunction

   function automatic char_type random_filler(bit small_alpha);
      if (small_alpha) begin
         return random_case(LOWER_FIRST + char_type'($urandom_range(1)));
      end
      return char_type'($urandom_range(1, 255));
   endfunction

   task automatic send_char(char_type c, logic is_end);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_char <= c;
      req_ch.text_end  <= is_end;
      do @(posedge clock); while (!req_ch.ready);
      tracker.take_char(c, is_end);
      chars_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
      texts_sent++;
   endtask

   task automatic send_string(string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      send_text();
   endtask

   // hold off the sender until every pending result has drained
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_pattern(logic [WORD_BITS-1:0] low, logic [WORD_BITS-1:0] high,
                                  logic [LEN_BITS-1:0] len);
      settle();
      write_reg(CSR_PATTERN_LOW, low);
      write_reg(CSR_PATTERN_HIGH, high);
      write_reg(CSR_PATTERN_LENGTH, WORD_BITS'(len));
   endtask

   initial begin
      logic [WORD_BITS-1:0] low_w;
      logic [WORD_BITS-1:0] high_w;
      logic [LEN_BITS-1:0]  len_code;
      int                   eff_len;
      int                   tlen;
      int                   pos;
      int                   pick;
      int                   n_texts;
      int                   rand_start;
      bit                   small_alpha;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.text_char <= '0;
      req_ch.text_end  <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_PATTERN_LOW;
      csr_wdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pattern out of reset matches at once
      send_string("x");

      // folding on both sides, then a length change in the middle of a text
      program_pattern(64'h0000_0000_0063_4261, '0, 5'd3);
      send_string("xAbC");
      send_char("x", 1'b0);
      settle();
      write_reg(CSR_PATTERN_LENGTH, WORD_BITS'(1));
      send_char("A", 1'b1);
      texts_sent++;

      // pattern of zero bytes: cleared window must not count, zero chars are plain chars
      program_pattern(64'h0000_0000_0071_0000, '0, 5'd3);
      send_string("q");
      text_buf = '{8'h00, 8'h00, "Q"};
      send_text();

      // length code above the window clamps to the full 16 characters
      program_pattern(64'h4142_4344_4546_4748, '1, 5'd31);
      text_buf.delete();
      for (int i = 0; i < 8; i++) text_buf.push_back(char_type'("h" - i));
      repeat (8) text_buf.push_back(8'hFF);
      send_text();

      rand_start = chars_sent;
      while (chars_sent - rand_start < RANDOM_CHARS) begin
         small_alpha = ($urandom_range(99) < 35);
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (small_alpha) pat_bytes[k] = random_filler(1'b1);
            else if ($urandom_range(3) == 0) pat_bytes[k] = char_type'($urandom_range(1, 255));
            else pat_bytes[k] = random_case(LOWER_FIRST + char_type'($urandom_range(25)));
         end
         for (int k = 0; k < WORD_CHARS; k++) begin
            low_w[k*CHAR_BITS +: CHAR_BITS]  = pat_bytes[k];
            high_w[k*CHAR_BITS +: CHAR_BITS] = pat_bytes[k+WORD_CHARS];
         end
         pick = $urandom_range(99);
         if (pick < 8) len_code = '0;
         else if (pick < 16) len_code = LEN_BITS'($urandom_range(MAX_PATTERN + 1, 31));
         else if (pick < 28) len_code = LEN_BITS'(MAX_PATTERN);
         else len_code = LEN_BITS'($urandom_range(1, MAX_PATTERN - 1));
         eff_len = (len_code > MAX_PATTERN) ? MAX_PATTERN : int'(len_code);
         program_pattern(low_w, high_w, len_code);

         n_texts = $urandom_range(3, 8);
         repeat (n_texts) begin
            gaps_on = !((chars_sent - rand_start) >= 400 && (chars_sent - rand_start) < 800);
            tlen = $urandom_range(1, 12 + 2 * eff_len);
            text_buf.delete();
            repeat (tlen) text_buf.push_back(random_filler(small_alpha));
            if (eff_len != 0 && tlen >= eff_len && $urandom_range(99) < 70) begin
               // now and then a near miss first, then the real occurrence somewhere
               if ($urandom_range(99) < 30) begin
                  pos = $urandom_range(0, tlen - eff_len);
                  for (int k = 0; k < eff_len; k++) text_buf[pos+k] = random_case(pat_bytes[k]);
                  text_buf[pos+eff_len-1] = (text_buf[pos+eff_len-1] == 8'hFF) ?
                                            8'hFE : text_buf[pos+eff_len-1] + 8'd1;
               end
               pos = $urandom_range(0, tlen - eff_len);
               for (int k = 0; k < eff_len; k++) text_buf[pos+k] = random_case(pat_bytes[k]);
            end
            send_text();
         end
      end
      gaps_on = 1'b1;

      req_ch.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d texts with %0d characters, %0d results checked",
               texts_sent, chars_sent, tracker.checked);
      $display("%0d texts held the pattern, %0d of them past the position range",
               tracker.hits, tracker.overflows);
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cisf_pkg.sv
rtl/cisf_if.sv
rtl/case_insensitive_substring_find.sv
tb/sv/tb.sv
